/* rtl/core/assert_macros.svh */
// Assertion helpers used by the top-level RTL file of the octet kernel.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define P3J_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay before the consequent.
`define P3J_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

/* rtl/core/p3j_pkg.sv */
package p3j_pkg;

	// Operand widths of the arithmetic levels.
	localparam int QW   = 72;
	localparam int WR   = 160;
	localparam int MW   = 96;
	localparam int NW   = 300;
	localparam int DW   = 356;
	localparam int RW   = 412;
	localparam int OUTW = 56;
	localparam int QBITS = 56;
	localparam int NUM_SHIFT = 89;

	// Cosine unit latency in cycles.
	localparam int CLAT = 6;
	// Restoring divider latency: set-up, one stage per quotient bit, output.
	localparam int DIV_LAT = QBITS + 2;

	localparam logic signed [33:0] COS_COEF [5] = '{
		34'sd1073741824, -34'sd1324675879, 34'sd272375560, -34'sd22401992, 34'sd960487
	};

	localparam logic signed [OUTW-1:0] KV_MAX = {1'b0, {(OUTW-1){1'b1}}};
	localparam logic signed [OUTW-1:0] KV_MIN = {1'b1, {(OUTW-1){1'b0}}};

	typedef struct packed {
		logic [47:0] pp;
		logic [47:0] k1k1;
		logic [47:0] kkkk;
		logic [47:0] kkp;
		logic [47:0] kkk1;
		logic [47:0] pk1;
		logic [47:0] mm;
		logic [23:0] m;
	} mag_t;

endpackage

/* rtl/core/p3j_delay.sv */
module p3j_delay #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] line_s [DEPTH];

	always_ff @(posedge clk) begin
		line_s[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			line_s[i] <= line_s[i-1];
		end
	end

	assign dout = line_s[DEPTH-1];

endmodule

/* rtl/core/p3j_cos.sv */
module p3j_cos (
	input  logic               clk,
	input  logic [15:0]        diff,
	output logic signed [17:0] cos_val
);

	logic [16:0] d0;
	logic [16:0] d1;
	logic        neg;

	logic [30:0]        sq_s  [4];
	logic               neg_s [5];
	logic signed [33:0] acc_s [1:4];

	logic [30:0] cl;
	logic [16:0] cmag;

	// Fold the difference into the first quadrant.
	always_comb begin
		d0 = {1'b0, diff};
		if (d0 > 17'd32768) begin
			d0 = 17'd65536 - d0;
		end
		d1  = d0;
		neg = 1'b0;
		if (d0 > 17'd16384) begin
			d1  = 17'd32768 - d0;
			neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s[0]  <= (31'(d1) * 31'(d1)) << 2;
		neg_s[0] <= neg;
	end

	// One Horner step per stage.
	for (genvar k = 1; k <= 4; k++) begin : g_horner
		logic signed [33:0] accp;
		logic signed [65:0] prod;
		if (k == 1) begin : g_first
			assign accp = p3j_pkg::COS_COEF[4];
		end else begin : g_next
			assign accp = acc_s[k-1];
		end
		assign prod = 66'($signed({1'b0, sq_s[k-1]})) * 66'(accp);
		always_ff @(posedge clk) begin
			acc_s[k] <= 34'(66'(p3j_pkg::COS_COEF[4-k]) + (prod >>> 30));
			neg_s[k] <= neg_s[k-1];
		end
		if (k < 4) begin : g_sq
			always_ff @(posedge clk) begin
				sq_s[k] <= sq_s[k-1];
			end
		end
	end

	always_comb begin
		if (acc_s[4] < 0) begin
			cl = '0;
		end else if (acc_s[4] > 34'sd1073741824) begin
			cl = 31'd1073741824;
		end else begin
			cl = acc_s[4][30:0];
		end
		cmag = 17'((cl + 31'd8192) >> 14);
	end

	always_ff @(posedge clk) begin
		cos_val <= neg_s[4] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
	end

endmodule

/* rtl/core/p3j_mul.sv */
module p3j_mul #(
	parameter int AW = 72,
	parameter int BW = 72
) (
	input  logic                     clk,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int NDIG = (BW + 31) / 32;
	localparam int DGW  = NDIG * 32;
	localparam int NDA  = (AW + 31) / 32;
	localparam int AGW  = NDA * 32;
	localparam int SW   = AGW + DGW;

	logic [AGW-1:0] ma_s  [NDIG+1];
	logic [DGW-1:0] mb_s  [NDIG+1];
	logic [SW-1:0]  acc_s [NDIG+1];
	logic           sg_s  [NDIG+1];

	logic [AW-1:0]  amag;
	logic [DGW-1:0] bext;

	assign amag = a[AW-1] ? AW'(-a) : AW'(a);
	assign bext = DGW'(b);

	// Magnitudes and product sign; the magnitude product is built one
	// 32-bit digit of b per stage.
	always_ff @(posedge clk) begin
		ma_s[0]  <= AGW'(amag);
		mb_s[0]  <= b[BW-1] ? -bext : bext;
		sg_s[0]  <= a[AW-1] ^ b[BW-1];
		acc_s[0] <= '0;
	end

	// Each stage multiplies every 32-bit digit of a by the current digit of b.
	// Partial products of even and odd digits do not overlap, so they are
	// packed side by side and added to the running sum.
	for (genvar k = 1; k <= NDIG; k++) begin : g_dig
		logic [AGW+31:0] ev;
		logic [AGW+31:0] od;

		always_comb begin
			ev = '0;
			od = '0;
			for (int i = 0; i < NDA; i += 2) begin
				ev[32*i +: 64] = 64'(ma_s[k-1][32*i +: 32]) *
					64'(mb_s[k-1][32*(k-1) +: 32]);
			end
			for (int i = 1; i < NDA; i += 2) begin
				od[32*i +: 64] = 64'(ma_s[k-1][32*i +: 32]) *
					64'(mb_s[k-1][32*(k-1) +: 32]);
			end
		end

		always_ff @(posedge clk) begin
			acc_s[k] <= acc_s[k-1] + ((SW'(ev) + SW'(od)) << (32*(k-1)));
			ma_s[k]  <= ma_s[k-1];
			mb_s[k]  <= mb_s[k-1];
			sg_s[k]  <= sg_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		p <= sg_s[NDIG] ? -$signed((AW+BW)'(acc_s[NDIG])) : $signed((AW+BW)'(acc_s[NDIG]));
	end

endmodule

/* rtl/core/p3j_div.sv */
module p3j_div (
	input  logic                                clk,
	input  logic signed [p3j_pkg::NW-1:0]       num,
	input  logic [p3j_pkg::DW-1:0]              den,
	output logic signed [p3j_pkg::OUTW-1:0]     kernel_value,
	output logic                                overflowed
);

	localparam int RW = p3j_pkg::RW;
	localparam int QB = p3j_pkg::QBITS;

	logic [RW-1:0]     rem_s [QB+1];
	logic [RW-1:0]     d2_s  [QB+1];
	logic [QB-1:0]     q_s   [QB+1];
	logic              neg_s [QB+1];
	logic              sat_s [QB+1];

	logic [p3j_pkg::NW-1:0] nmag;
	logic [RW-1:0]          rem0;
	logic [RW-1:0]          d2w;

	// Rounded quotient: (|num| * 2^89 + den) / (2 den), halves away from zero.
	always_comb begin
		nmag = num[p3j_pkg::NW-1] ? p3j_pkg::NW'(-num) : p3j_pkg::NW'(num);
		rem0 = (RW'(nmag) << p3j_pkg::NUM_SHIFT) + RW'(den);
		d2w  = RW'(den) << 1;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= rem0;
		d2_s[0]  <= d2w;
		q_s[0]   <= '0;
		neg_s[0] <= num[p3j_pkg::NW-1];
		sat_s[0] <= rem0 >= (d2w << QB);
	end

	for (genvar j = 0; j < QB; j++) begin : g_bit
		logic [RW-1:0] trial;
		logic          fit;
		assign trial = d2_s[j] << (QB - 1 - j);
		assign fit   = rem_s[j] >= trial;
		always_ff @(posedge clk) begin
			rem_s[j+1] <= fit ? rem_s[j] - trial : rem_s[j];
			q_s[j+1]   <= q_s[j] | (QB'(fit) << (QB - 1 - j));
			d2_s[j+1]  <= d2_s[j];
			neg_s[j+1] <= neg_s[j];
			sat_s[j+1] <= sat_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (!neg_s[QB]) begin
			if (sat_s[QB] || (q_s[QB] > QB'(p3j_pkg::KV_MAX))) begin
				kernel_value <= p3j_pkg::KV_MAX;
				overflowed   <= 1'b1;
			end else begin
				kernel_value <= $signed(q_s[QB]);
				overflowed   <= 1'b0;
			end
		end else begin
			if (sat_s[QB] || (q_s[QB] > QB'(p3j_pkg::KV_MIN))) begin
				kernel_value <= p3j_pkg::KV_MIN;
				overflowed   <= 1'b1;
			end else begin
				kernel_value <= -$signed(q_s[QB]);
				overflowed   <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/octet_p3j_kernel.sv */
// Octet P-wave (3PJ) integrand kernel, fully pipelined.
// Requests enter on start with the six momentum fields; busy is never raised, so
// a request may be issued on every clock cycle.
// Each request yields exactly one result: done is high
// for one cycle with kernel_value (signed Q16.40) and overflowed alongside.
// Throughput is one request per cycle. The latency is set by the chain of
// arithmetic levels: a six-stage cosine unit, three sum stages, two levels of
// wide multipliers that take one 32-bit digit per stage, the final multiply
// that forms the denominator, and a 58-stage restoring divider that settles
// one quotient bit per stage.
// The heavy-quark mass is written through cfg_valid/cfg_ready/heavy_quark_mass;
// cfg_ready is always high. Each request samples the mass as it enters, so
// requests already in flight keep the value they started with.
// Reset clears the valid line and returns the mass to 1.5 GeV; arithmetic
// registers are not reset. Results cannot be held off by the receiver: done
// is a strobe and the value is lost unless captured in that cycle.
`include "assert_macros.svh"

module octet_p3j_kernel (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [23:0]                pair_momentum,
	input  logic [15:0]                pair_angle,
	input  logic [23:0]                first_gluon_momentum,
	input  logic [15:0]                first_gluon_angle,
	input  logic [23:0]                loop_momentum,
	input  logic [15:0]                loop_angle,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [23:0]                heavy_quark_mass,
	output logic                       done,
	output logic signed [55:0]         kernel_value,
	output logic                       overflowed
);

	localparam int QW  = p3j_pkg::QW;
	localparam int WR  = p3j_pkg::WR;
	localparam int MW  = p3j_pkg::MW;
	localparam int NW  = p3j_pkg::NW;
	localparam int DW  = p3j_pkg::DW;
	localparam int ML1 = (QW + 31) / 32 + 2;
	localparam int ML2 = (WR + 31) / 32 + 2;
	localparam int ML3 = (MW + 31) / 32 + 2;
	localparam int LAT = 1 + p3j_pkg::CLAT + 3 + ML1 + 1 + ML2 + ML3 + p3j_pkg::DIV_LAT;

	logic [23:0]   mass_q;
	logic [LAT-1:0] vld_q;
	logic          take;

	// The block never stalls.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= 24'd98304;
			vld_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mass_q <= heavy_quark_mass;
			end
			vld_q <= {vld_q[LAT-2:0], take};
		end
	end

	assign done = vld_q[LAT-1];

	// Stage 1: capture the request; a mass of zero is read as one LSB.
	logic [23:0] p_s1, k1_s1, kk_s1, m_s1;
	logic [15:0] ap_s1, a1_s1, ak_s1;

	always_ff @(posedge clk) begin
		p_s1  <= pair_momentum;
		k1_s1 <= first_gluon_momentum;
		kk_s1 <= loop_momentum;
		ap_s1 <= pair_angle;
		a1_s1 <= first_gluon_angle;
		ak_s1 <= loop_angle;
		m_s1  <= (mass_q == 24'd0) ? 24'd1 : mass_q;
	end

	// Cosines of the three angle differences.
	logic [15:0]        dpk, dk1k, dpk1;
	logic signed [17:0] cpk_s7, ck1k_s7, cpk1_s7;

	assign dpk  = ap_s1 - ak_s1;
	assign dk1k = a1_s1 - ak_s1;
	assign dpk1 = ap_s1 - a1_s1;

	p3j_cos u_cos_pk   (.clk(clk), .diff(dpk),  .cos_val(cpk_s7));
	p3j_cos u_cos_k1k  (.clk(clk), .diff(dk1k), .cos_val(ck1k_s7));
	p3j_cos u_cos_pk1  (.clk(clk), .diff(dpk1), .cos_val(cpk1_s7));

	// Stage 2: products of magnitudes, then aligned with the cosines.
	p3j_pkg::mag_t mag_s2, mag_s7;

	always_ff @(posedge clk) begin
		mag_s2.pp   <= 48'(p_s1) * 48'(p_s1);
		mag_s2.k1k1 <= 48'(k1_s1) * 48'(k1_s1);
		mag_s2.kkkk <= 48'(kk_s1) * 48'(kk_s1);
		mag_s2.kkp  <= 48'(kk_s1) * 48'(p_s1);
		mag_s2.kkk1 <= 48'(kk_s1) * 48'(k1_s1);
		mag_s2.pk1  <= 48'(p_s1) * 48'(k1_s1);
		mag_s2.mm   <= 48'(m_s1) * 48'(m_s1);
		mag_s2.m    <= m_s1;
	end

	p3j_delay #(.W($bits(p3j_pkg::mag_t)), .DEPTH(p3j_pkg::CLAT - 1)) u_dly_mag (
		.clk(clk), .din(mag_s2), .dout(mag_s7)
	);

	// Stage 8: cosine-weighted cross terms and m^3.
	logic signed [QW-1:0] tpk_s8, tk1k_s8, tpk1_s8;
	logic [47:0]          pp_s8, k1k1_s8, kkkk_s8, mm_s8;
	logic [QW-1:0]        m3_s8;

	always_ff @(posedge clk) begin
		tpk_s8  <= QW'($signed({1'b0, mag_s7.kkp, 2'b00})) * QW'(cpk_s7);
		tk1k_s8 <= QW'($signed({1'b0, mag_s7.kkk1, 2'b00})) * QW'(ck1k_s7);
		tpk1_s8 <= QW'($signed({1'b0, mag_s7.pk1, 1'b0})) * QW'(cpk1_s7);
		pp_s8   <= mag_s7.pp;
		k1k1_s8 <= mag_s7.k1k1;
		kkkk_s8 <= mag_s7.kkkk;
		mm_s8   <= mag_s7.mm;
		m3_s8   <= QW'(mag_s7.mm) * QW'(mag_s7.m);
	end

	// Stage 9: lT^2 (clamped at zero), k1.l and p.l, all on the 2^-50 scale.
	logic [QW-1:0]        sq_sum;
	logic signed [QW-1:0] l_raw;
	logic signed [QW-1:0] l_s9, a_s9, b_s9;
	logic [47:0]          k1k1_s9, mm_s9;
	logic [QW-1:0]        m3_s9;

	always_comb begin
		sq_sum = QW'({kkkk_s8, 2'b00}) + QW'(pp_s8) + QW'(k1k1_s8);
		l_raw  = $signed(sq_sum << 16) - tpk_s8 + tk1k_s8 - tpk1_s8;
	end

	always_ff @(posedge clk) begin
		l_s9    <= l_raw[QW-1] ? '0 : l_raw;
		a_s9    <= tk1k_s8 - tpk1_s8 + $signed(QW'(k1k1_s8) << 17);
		b_s9    <= tpk_s8 - $signed(QW'(pp_s8) << 17) + tpk1_s8;
		k1k1_s9 <= k1k1_s8;
		mm_s9   <= mm_s8;
		m3_s9   <= m3_s8;
	end

	// Stage 10: k1^2, m^2, kappa^2 on the 2^-50 scale, D and b - a.
	logic signed [QW-1:0] kq_s10, mq_s10, kap_s10, d_s10, w_s10, l_s10, a_s10;
	logic signed [MW-1:0] m18_s10, m18_s23;

	always_ff @(posedge clk) begin
		kq_s10  <= $signed(QW'(k1k1_s9) << 18);
		mq_s10  <= $signed(QW'(mm_s9) << 18);
		kap_s10 <= $signed((QW'(k1k1_s9) + (QW'(mm_s9) << 2)) << 18);
		d_s10   <= l_s9 + $signed(QW'(k1k1_s9) << 16) + $signed(QW'(mm_s9) << 18);
		w_s10   <= b_s9 - a_s9;
		l_s10   <= l_s9;
		a_s10   <= a_s9;
		m18_s10 <= $signed((MW'(m3_s9) << 4) + (MW'(m3_s9) << 1));
	end

	p3j_delay #(.W(MW), .DEPTH(ML1 + 1 + ML2)) u_dly_m18 (
		.clk(clk), .din(m18_s10), .dout(m18_s23)
	);

	// First multiplier level.
	logic signed [2*QW-1:0] kl_m, a2_m, d2_m, ww_m, ml_m, ka_m, kk_m, md_m, wd_m;

	p3j_mul #(.AW(QW), .BW(QW)) u_mul_kl (.clk(clk), .a(kq_s10), .b(l_s10), .p(kl_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_a2 (.clk(clk), .a(a_s10), .b(a_s10), .p(a2_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_d2 (.clk(clk), .a(d_s10), .b(d_s10), .p(d2_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_ww (.clk(clk), .a(w_s10), .b(w_s10), .p(ww_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_ml (.clk(clk), .a(mq_s10), .b(l_s10), .p(ml_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_ka (.clk(clk), .a(kq_s10), .b(a_s10), .p(ka_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_kk (.clk(clk), .a(kq_s10), .b(kap_s10), .p(kk_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_md (.clk(clk), .a(mq_s10), .b(d_s10), .p(md_m));
	p3j_mul #(.AW(QW), .BW(QW)) u_mul_wd (.clk(clk), .a(w_s10), .b(d_s10), .p(wd_m));

	// Stage 16: combine into the factors of the four numerator terms.
	logic signed [WR-1:0] x1_s16, x3_s16, y4_s16, d2_s16, ka_s16, wd_s16, md_s16, kk_s16;

	always_ff @(posedge clk) begin
		x1_s16 <= (WR'(kl_m) <<< 3) - (WR'(a2_m) <<< 2);
		x3_s16 <= (WR'(kl_m) - WR'(a2_m)) <<< 4;
		y4_s16 <= WR'(ww_m) + (WR'(ml_m) <<< 2);
		d2_s16 <= WR'(d2_m);
		ka_s16 <= WR'(ka_m);
		wd_s16 <= WR'(wd_m);
		md_s16 <= WR'(md_m);
		kk_s16 <= WR'(kk_m);
	end

	// Second multiplier level: the four terms and D^4.
	logic signed [2*WR-1:0] t1_m, t2_m, t3_m, t4_m, d4_m;

	p3j_mul #(.AW(WR), .BW(WR)) u_mul_t1 (.clk(clk), .a(x1_s16), .b(d2_s16), .p(t1_m));
	p3j_mul #(.AW(WR), .BW(WR)) u_mul_t2 (.clk(clk), .a(ka_s16), .b(wd_s16), .p(t2_m));
	p3j_mul #(.AW(WR), .BW(WR)) u_mul_t3 (.clk(clk), .a(x3_s16), .b(md_s16), .p(t3_m));
	p3j_mul #(.AW(WR), .BW(WR)) u_mul_t4 (.clk(clk), .a(kk_s16), .b(y4_s16), .p(t4_m));
	p3j_mul #(.AW(WR), .BW(WR)) u_mul_d4 (.clk(clk), .a(d2_s16), .b(d2_s16), .p(d4_m));

	// Stage 24: numerator, twice the integrand times 18 m^3 D^4.
	logic signed [NW-1:0] num_s24, num_s28;

	always_ff @(posedge clk) begin
		num_s24 <= NW'(t1_m) + (NW'(t2_m) <<< 2) - NW'(t3_m) + NW'(t4_m);
	end

	p3j_delay #(.W(NW), .DEPTH(ML3 - 1)) u_dly_num (
		.clk(clk), .din(num_s24), .dout(num_s28)
	);

	// Denominator 18 m^3 D^4.
	logic signed [NW-1:0]    d4n;
	logic signed [NW+MW-1:0] den_m;

	assign d4n = NW'(d4_m);

	p3j_mul #(.AW(NW), .BW(MW)) u_mul_den (.clk(clk), .a(d4n), .b(m18_s23), .p(den_m));

	p3j_div u_div (
		.clk         (clk),
		.num         (num_s28),
		.den         (DW'(den_m)),
		.kernel_value(kernel_value),
		.overflowed  (overflowed)
	);

	`P3J_ASSERT_DLY(a_latency, clk, arst_n, take, LAT, done,
		"request did not produce a result after the pipeline latency")
	`P3J_ASSERT_IMP(a_origin, clk, arst_n, done, $past(take, LAT),
		"result strobe without a matching request")
	`P3J_ASSERT_IMP(a_clip, clk, arst_n, done && overflowed,
		kernel_value == p3j_pkg::KV_MAX || kernel_value == p3j_pkg::KV_MIN,
		"overflow flagged on a value that is not at a limit")

endmodule
